// ----- hdl/btm_pkg.sv -----
package btm_pkg;

  localparam int COORD_W   = 23;  // input coordinate width, signed
  localparam int WIDE_W    = 24;  // coordinate sums and magnitudes
  localparam int SCORE_W   = 25;  // one L1 score
  localparam int LIMIT_W   = 24;
  localparam int TOL_W     = 8;
  localparam int INDEX_W   = 5;   // entry_index / match_index field width
  localparam int CFG_IDX_W = 3;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [LIMIT_W-1:0] EXACT_RST      = 24'd5120;
  localparam logic [LIMIT_W-1:0] LEGACY_RST     = 24'd14400;
  localparam logic [LIMIT_W-1:0] SPAN_RST       = 24'd2048;
  localparam logic [LIMIT_W-1:0] CENTER_RST     = 24'd12288;
  localparam logic [LIMIT_W-1:0] GAP_RST        = 24'd1024;
  localparam logic [LIMIT_W-1:0] AMB_SPAN_RST   = 24'd3072;
  localparam logic [LIMIT_W-1:0] AMB_CENTER_RST = 24'd16384;
  localparam logic [TOL_W-1:0]   TIE_RST        = 8'd2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;
  typedef logic        [WIDE_W-1:0]  mag_t;
  typedef logic        [SCORE_W-1:0] score_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t max_x;
    coord_t max_y;
  } rect_t;

  // marker that travels with each entry through the scoring pipe
  typedef struct packed {
    logic usable;
    logic last;
  } tag_t;

  typedef enum logic [1:0] {
    ST_MATCH = 2'd0,
    ST_EMPTY = 2'd1,
    ST_AMBIG = 2'd2,
    ST_FAR   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXACT      = 3'd0,
    REG_LEGACY     = 3'd1,
    REG_SPAN       = 3'd2,
    REG_CENTER     = 3'd3,
    REG_GAP        = 3'd4,
    REG_AMB_SPAN   = 3'd5,
    REG_AMB_CENTER = 3'd6,
    REG_TIE        = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_DECIDE
  } state_t;

endpackage

// ----- hdl/btm_if.sv -----
interface btm_in_if import btm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic        [INDEX_W-1:0] entry_index;
  logic signed [COORD_W-1:0] min_x;
  logic signed [COORD_W-1:0] min_y;
  logic signed [COORD_W-1:0] max_x;
  logic signed [COORD_W-1:0] max_y;
  logic                      dynamic_entry;
  logic                      allow_loose;

  modport source (output valid, mode, entry_index, min_x, min_y, max_x, max_y,
                  dynamic_entry, allow_loose, input ready);
  modport sink   (input valid, mode, entry_index, min_x, min_y, max_x, max_y,
                  dynamic_entry, allow_loose, output ready);
endinterface

interface btm_out_if import btm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [INDEX_W-1:0] match_index;

  modport source (output valid, status, match_index, input ready);
  modport sink   (input valid, status, match_index, output ready);
endinterface

interface btm_cfg_if import btm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [LIMIT_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/btm_score.sv -----
// Three-stage scoring pipe: one table entry in per cycle; the corner/span/center
// L1 scores come out of the stage C registers.
module btm_score import btm_pkg::*; #(
  parameter int IDX_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rect_t            qry,
  input  rect_t            ref_rect,
  input  tag_t             tag_in,
  input  logic [IDX_W-1:0] idx_in,
  output score_t           corner,
  output score_t           span,
  output score_t           center,
  output tag_t             tag_out,
  output logic [IDX_W-1:0] idx_out
);

  function automatic mag_t abs_diff(wide_t a, wide_t b);
    return (a >= b) ? mag_t'(a - b) : mag_t'(b - a);
  endfunction

  function automatic wide_t sx(coord_t v);
    return wide_t'(v);
  endfunction

  // stage A: per-coordinate magnitudes, spans, doubled centers
  mag_t  a_dmnx_r, a_dmny_r, a_dmxx_r, a_dmxy_r;
  mag_t  a_rspx_r, a_rspy_r, a_qspx_r, a_qspy_r;
  wide_t a_rcx_r, a_rcy_r, a_qcx_r, a_qcy_r;
  tag_t  a_tag_r;
  logic [IDX_W-1:0] a_idx_r;

  // stage B: pair sums and differences
  score_t b_cor0_r, b_cor1_r;
  mag_t   b_spx_r, b_spy_r, b_cx_r, b_cy_r;
  tag_t   b_tag_r;
  logic [IDX_W-1:0] b_idx_r;

  // stage C: final scores
  score_t c_cor_r, c_span_r, c_cen_r;
  tag_t   c_tag_r;
  logic [IDX_W-1:0] c_idx_r;

  always_ff @(posedge clk) begin
    a_dmnx_r <= abs_diff(sx(qry.min_x), sx(ref_rect.min_x));
    a_dmny_r <= abs_diff(sx(qry.min_y), sx(ref_rect.min_y));
    a_dmxx_r <= abs_diff(sx(qry.max_x), sx(ref_rect.max_x));
    a_dmxy_r <= abs_diff(sx(qry.max_y), sx(ref_rect.max_y));
    a_rspx_r <= abs_diff(sx(ref_rect.max_x), sx(ref_rect.min_x));
    a_rspy_r <= abs_diff(sx(ref_rect.max_y), sx(ref_rect.min_y));
    a_qspx_r <= abs_diff(sx(qry.max_x), sx(qry.min_x));
    a_qspy_r <= abs_diff(sx(qry.max_y), sx(qry.min_y));
    a_rcx_r  <= sx(ref_rect.min_x) + sx(ref_rect.max_x);
    a_rcy_r  <= sx(ref_rect.min_y) + sx(ref_rect.max_y);
    a_qcx_r  <= sx(qry.min_x) + sx(qry.max_x);
    a_qcy_r  <= sx(qry.min_y) + sx(qry.max_y);
    a_idx_r  <= idx_in;

    b_cor0_r <= score_t'(a_dmnx_r) + score_t'(a_dmxx_r);
    b_cor1_r <= score_t'(a_dmny_r) + score_t'(a_dmxy_r);
    b_spx_r  <= abs_diff(wide_t'(a_qspx_r), wide_t'(a_rspx_r));
    b_spy_r  <= abs_diff(wide_t'(a_qspy_r), wide_t'(a_rspy_r));
    b_cx_r   <= abs_diff(a_qcx_r, a_rcx_r);
    b_cy_r   <= abs_diff(a_qcy_r, a_rcy_r);
    b_idx_r  <= a_idx_r;

    c_cor_r  <= b_cor0_r + b_cor1_r;
    c_span_r <= score_t'(b_spx_r) + score_t'(b_spy_r);
    c_cen_r  <= score_t'(b_cx_r) + score_t'(b_cy_r);
    c_idx_r  <= b_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_tag_r <= '0;
      b_tag_r <= '0;
      c_tag_r <= '0;
    end else begin
      a_tag_r <= tag_in;
      b_tag_r <= a_tag_r;
      c_tag_r <= b_tag_r;
    end
  end

  assign corner  = c_cor_r;
  assign span    = c_span_r;
  assign center  = c_cen_r;
  assign tag_out = c_tag_r;
  assign idx_out = c_idx_r;

endmodule

// ----- hdl/bounds_template_matcher_top.sv -----
// Channel  Dir  Beat contents                                        Handshake
// in_ch    in   mode, entry_index, min/max x/y, dynamic_entry,       valid/ready
//               allow_loose
// out_ch   out  status, match_index (one beat per query)             valid/ready
// cfg_ch   in   index (register 0..7), data                          valid/ready
//
// A write beat is taken in the idle state; in_ch.ready stays high after it.
// A query beat starts a scan: one table read per cycle, through the registered
// read port, into the three-stage scoring pipe, then a pipe drain and a decision
// state. The single table read port makes the scan serial, one entry at a time.
// The result sits in an output register; a stalled out_ch holds it. Writes are
// still taken meanwhile, but the next query waits in its decision cycle, with
// in_ch.ready low, until that register frees.
// rst_n (synchronous) clears control, config registers and usable bits; the
// rectangle table itself is not cleared. cfg_ch.ready is always high.
module bounds_template_matcher_top import btm_pkg::*; #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  btm_in_if.sink     in_ch,
  btm_out_if.source  out_ch,
  btm_cfg_if.sink    cfg_ch
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int EXT_W = IDX_W + INDEX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // ---------------------------------------------------------------------
  // ranking helpers
  // ---------------------------------------------------------------------
  // x + tol < h, i.e. x is below h by more than the tie tolerance
  function automatic logic below_tol(score_t x, score_t h, logic [TOL_W-1:0] tol);
    return ({1'b0, x} + (SCORE_W+1)'(tol)) < {1'b0, h};
  endfunction

  // candidate (l,s,c) ranks ahead of holder (hl,hs,hc)
  function automatic logic ranks_ahead(score_t l, score_t s, score_t c,
                                       score_t hl, score_t hs, score_t hc,
                                       logic [TOL_W-1:0] tol);
    logic lt_l, gt_l, lt_s, gt_s;
    lt_l = below_tol(l, hl, tol);
    gt_l = below_tol(hl, l, tol);
    lt_s = below_tol(s, hs, tol);
    gt_s = below_tol(hs, s, tol);
    return lt_l || (!gt_l && (lt_s || (!gt_s && (c < hc))));
  endfunction

  // ---------------------------------------------------------------------
  // config registers
  // ---------------------------------------------------------------------
  logic [LIMIT_W-1:0] exact_r, legacy_r, span_lim_r, center_lim_r;
  logic [LIMIT_W-1:0] gap_r, amb_span_r, amb_center_r;
  logic [TOL_W-1:0]   tie_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exact_r      <= EXACT_RST;
      legacy_r     <= LEGACY_RST;
      span_lim_r   <= SPAN_RST;
      center_lim_r <= CENTER_RST;
      gap_r        <= GAP_RST;
      amb_span_r   <= AMB_SPAN_RST;
      amb_center_r <= AMB_CENTER_RST;
      tie_r        <= TIE_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (reg_idx_t'(cfg_ch.index))
        REG_EXACT:      exact_r      <= cfg_ch.data;
        REG_LEGACY:     legacy_r     <= cfg_ch.data;
        REG_SPAN:       span_lim_r   <= cfg_ch.data;
        REG_CENTER:     center_lim_r <= cfg_ch.data;
        REG_GAP:        gap_r        <= cfg_ch.data;
        REG_AMB_SPAN:   amb_span_r   <= cfg_ch.data;
        REG_AMB_CENTER: amb_center_r <= cfg_ch.data;
        REG_TIE:        tie_r        <= cfg_ch.data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             in_acc, qry_start, wr_en, in_range;
  logic             issue, decide_go, out_free;
  logic [EXT_W-1:0] wr_ext;
  logic [IDX_W-1:0] wr_addr;

  score_t           sc_corner, sc_span, sc_center;
  tag_t             sc_tag;
  logic [IDX_W-1:0] sc_idx;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign qry_start = in_acc && (in_ch.mode == MODE_QUERY);
  // slots past the table are dropped
  assign wr_ext    = EXT_W'(in_ch.entry_index);
  assign in_range  = wr_ext < EXT_W'(TABLE_ENTRIES);
  assign wr_addr   = wr_ext[IDX_W-1:0];
  assign wr_en     = in_acc && (in_ch.mode == MODE_WRITE) && in_range;

  logic out_valid_r, out_valid_nxt;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (qry_start)          state_nxt = S_ISSUE;
      S_ISSUE:  if (cnt_r == LAST_IDX)  state_nxt = S_DRAIN;
      S_DRAIN:  if (sc_tag.last)        state_nxt = S_DECIDE;
      S_DECIDE: if (out_free)           state_nxt = S_IDLE;
      default:                          state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    issue       = 1'b0;
    decide_go   = 1'b0;
    case (state_r)
      S_IDLE:   in_ch.ready = 1'b1;
      S_ISSUE:  issue       = 1'b1;
      S_DRAIN:  ;
      S_DECIDE: decide_go   = out_free;
      default:  ;
    endcase
  end

  assign cnt_nxt = issue ? cnt_r + 1'b1 : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // query rectangle, held for the whole scan
  rect_t q_r;
  logic  loose_r;

  always_ff @(posedge clk) begin
    if (qry_start) begin
      q_r.min_x <= in_ch.min_x;
      q_r.min_y <= in_ch.min_y;
      q_r.max_x <= in_ch.max_x;
      q_r.max_y <= in_ch.max_y;
      loose_r   <= in_ch.allow_loose;
    end
  end

  // ---------------------------------------------------------------------
  // reference table: one write port, one registered read port
  // ---------------------------------------------------------------------
  rect_t                    ref_mem [TABLE_ENTRIES];
  rect_t                    rd_r;
  rect_t                    wr_rect;
  logic [TABLE_ENTRIES-1:0] usable_r;
  tag_t                     t0_r, t0_nxt;
  logic [IDX_W-1:0]         i0_r;

  assign wr_rect.min_x = in_ch.min_x;
  assign wr_rect.min_y = in_ch.min_y;
  assign wr_rect.max_x = in_ch.max_x;
  assign wr_rect.max_y = in_ch.max_y;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ref_mem[wr_addr] <= wr_rect;
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= ref_mem[cnt_r];
    i0_r <= cnt_r;
  end

  // unusable (dynamic or never written) entries travel as bubbles
  assign t0_nxt.usable = issue && usable_r[cnt_r];
  assign t0_nxt.last   = issue && (cnt_r == LAST_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usable_r <= '0;
      t0_r     <= '0;
    end else begin
      t0_r <= t0_nxt;
      if (wr_en) begin
        usable_r[wr_addr] <= !in_ch.dynamic_entry;
      end
    end
  end

  btm_score #(.IDX_W(IDX_W)) u_score (
    .clk      (clk),
    .rst_n    (rst_n),
    .qry      (q_r),
    .ref_rect (rd_r),
    .tag_in   (t0_r),
    .idx_in   (i0_r),
    .corner   (sc_corner),
    .span     (sc_span),
    .center   (sc_center),
    .tag_out  (sc_tag),
    .idx_out  (sc_idx)
  );

  // ---------------------------------------------------------------------
  // best / runner-up tracking
  // ---------------------------------------------------------------------
  logic             bv_r, bv_nxt, sv_r, sv_nxt;
  score_t           bl_r, bs_r, bc_r, sl_r, ss_r, sc_r;
  score_t           bl_nxt, bs_nxt, bc_nxt, sl_nxt, ss_nxt, sc_nxt;
  logic [IDX_W-1:0] bi_r, bi_nxt;
  logic             beat_b, beat_s;

  assign beat_b = !bv_r || ranks_ahead(sc_corner, sc_span, sc_center,
                                       bl_r, bs_r, bc_r, tie_r);
  assign beat_s = !sv_r || ranks_ahead(sc_corner, sc_span, sc_center,
                                       sl_r, ss_r, sc_r, tie_r);

  always_comb begin
    bv_nxt = bv_r;  bl_nxt = bl_r;  bs_nxt = bs_r;  bc_nxt = bc_r;  bi_nxt = bi_r;
    sv_nxt = sv_r;  sl_nxt = sl_r;  ss_nxt = ss_r;  sc_nxt = sc_r;
    if (qry_start) begin
      bv_nxt = 1'b0;
      sv_nxt = 1'b0;
    end else if (sc_tag.usable) begin
      if (beat_b) begin
        // old best drops to runner-up
        sv_nxt = bv_r;  sl_nxt = bl_r;  ss_nxt = bs_r;  sc_nxt = bc_r;
        bv_nxt = 1'b1;
        bl_nxt = sc_corner;
        bs_nxt = sc_span;
        bc_nxt = sc_center;
        bi_nxt = sc_idx;
      end else if (beat_s) begin
        sv_nxt = 1'b1;
        sl_nxt = sc_corner;
        ss_nxt = sc_span;
        sc_nxt = sc_center;
      end
    end
  end

  always_ff @(posedge clk) begin
    bl_r <= bl_nxt;  bs_r <= bs_nxt;  bc_r <= bc_nxt;  bi_r <= bi_nxt;
    sl_r <= sl_nxt;  ss_r <= ss_nxt;  sc_r <= sc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      bv_r <= bv_nxt;
      sv_r <= sv_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // decision
  // ---------------------------------------------------------------------
  logic             exact, close, ambig;
  score_t           gap;
  status_t          status_d;
  logic [EXT_W-1:0] bi_ext;
  logic [INDEX_W-1:0] index_d;

  assign exact = bl_r <= score_t'(exact_r);
  assign close = loose_r && (bl_r <= score_t'(legacy_r)) &&
                 (bs_r <= score_t'(span_lim_r)) && (bc_r <= score_t'(center_lim_r));
  assign gap   = (sl_r >= bl_r) ? sl_r - bl_r : bl_r - sl_r;
  assign ambig = sv_r && (sl_r <= score_t'(legacy_r)) && (gap <= score_t'(gap_r)) &&
                 (ss_r <= score_t'(amb_span_r)) && (sc_r <= score_t'(amb_center_r));

  always_comb begin
    if (!bv_r)               status_d = ST_EMPTY;
    else if (ambig)          status_d = ST_AMBIG;   // ambiguity beats a match
    else if (exact || close) status_d = ST_MATCH;
    else                     status_d = ST_FAR;
  end

  assign bi_ext  = EXT_W'(bi_r);
  assign index_d = (status_d == ST_MATCH) ? bi_ext[INDEX_W-1:0] : '0;

  // ---------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------
  status_t            out_status_r;
  logic [INDEX_W-1:0] out_index_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (decide_go)         out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (decide_go) begin
      out_status_r <= status_d;
      out_index_r  <= index_d;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.match_index = out_index_r;

endmodule

// ----- hdl/btm_checker.sv -----
module btm_checker import btm_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_mode,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_status,
  input logic [INDEX_W-1:0] out_match_index
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
                                $stable(out_match_index))
    else $error("result beat changed while stalled");

  // index is zero unless the status is a match
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_MATCH) |-> out_match_index == '0)
    else $error("match_index nonzero without a match");

  // a query beat makes the block busy
  a_qry_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == MODE_QUERY) |=> !in_ready)
    else $error("ready after query beat");

  // a table write leaves the block ready
  a_wr_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == MODE_WRITE) |=> in_ready)
    else $error("not ready after write beat");

  // a new result only comes out of a busy period
  a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a query in flight");

endmodule

bind bounds_template_matcher_top btm_checker u_btm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_mode         (in_ch.mode),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_match_index (out_ch.match_index)
);
